[rtl/core/rpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_pkg
// Shared types, codes and helpers of the RGB PWM gamma color-loop unit.
// ----------------------------------------------------------------------------
package rpg_pkg;

   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_SET   = 3'd1;
   localparam logic [2:0] KIND_LOOP  = 3'd2;
   localparam logic [2:0] KIND_STEP  = 3'd3;
   localparam logic [2:0] KIND_STOP  = 3'd4;

   localparam logic [8:0] LEVEL_MAX  = 9'd256;
   localparam logic [8:0] SLOT_TOP   = 9'd256;
   localparam logic [8:0] RELOAD_RST = 9'd255;
   localparam logic [1:0] PHASE_RED  = 2'd0;
   localparam logic [1:0] PHASE_GRN  = 2'd1;
   localparam logic [1:0] PHASE_BLU  = 2'd2;
   localparam logic [1:0] PHASE_IDLE = 2'd3;
   localparam logic [1:0] CH_LAST    = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0] kind;
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
      logic [8:0] brightness;
   } req_type;

   typedef struct packed {
      logic red_pin;
      logic green_pin;
      logic blue_pin;
      logic effect_running;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_SET,
      OP_LOOP,
      OP_STEP,
      OP_STOP,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
      logic [8:0] brightness;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } work_link_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_SQ,
      ST_CU,
      ST_SC
   } back_state_type;

   function automatic logic [8:0] sat_level(input logic [8:0] x);
      sat_level = (x > LEVEL_MAX) ? LEVEL_MAX : x;
   endfunction

endpackage

[rtl/core/rgb_pwm_gamma_colorloop_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pwm_gamma_colorloop_unit
// Three-channel RGB PWM with gamma-corrected, brightness-scaled duties and a
// red-green-blue color-loop effect. One result per request.
//
//   channel  | ports                          | accepted when
//   ---------+--------------------------------+------------------------
//   request  | req_push, req_full, req_item   | req_push && !req_full
//   response | rsp_pop, rsp_empty, rsp_item   | rsp_pop && !rsp_empty
//
// Tick, stop and unused kinds complete in the back-end idle state; set color,
// color-loop start and a step while the loop runs make 3 passes per channel over
// the one 17x9 multiplier (square, cube, brightness scale), a step while idle
// only a visit to the step state. Synchronous reset; no clearing pass. Either
// side stalls on its own through the two-entry request and result queues.
// ----------------------------------------------------------------------------
module rgb_pwm_gamma_colorloop_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rpg_pkg::req_type req_item,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output rpg_pkg::rsp_type rsp_item
);
   import rpg_pkg::*;

   work_link_type link;
   logic          work_pop;
   logic          back_push;
   logic          back_full;
   rsp_type       back_item;

   rpg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .link     (link),
      .work_pop (work_pop)
   );

   rpg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .link     (link),
      .work_pop (work_pop),
      .rsp_full (back_full),
      .rsp_push (back_push),
      .rsp_item (back_item)
   );

   rpg_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_item (back_item),
      .full      (back_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_pop_has_work: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> link.valid)
      else $error("back end took work from an empty queue");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      back_push |-> !back_full)
      else $error("result pushed into a full queue");

   a_pop_then_push_only_if_room: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> !back_full)
      else $error("work started without room for its result");

endmodule

[rtl/core/rpg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_front
// Accepts request transactions, decodes the kind, saturates the levels and
// holds the decoded work in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rpg_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  rpg_pkg::req_type       req_item,
   output logic                   req_full,
   output rpg_pkg::work_link_type link,
   input  logic                   work_pop
);
   import rpg_pkg::*;

   work_type   queue_mem [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       take;
   work_type   decoded;

   always_comb begin
      decoded.red        = sat_level(req_item.red);
      decoded.green      = sat_level(req_item.green);
      decoded.blue       = sat_level(req_item.blue);
      decoded.brightness = sat_level(req_item.brightness);
      unique case (req_item.kind)
         KIND_TICK: decoded.op = OP_TICK;
         KIND_SET:  decoded.op = OP_SET;
         KIND_LOOP: decoded.op = OP_LOOP;
         KIND_STEP: decoded.op = OP_STEP;
         KIND_STOP: decoded.op = OP_STOP;
         default:   decoded.op = OP_NONE;
      endcase
   end

   assign req_full   = (count_ff == 2'(QUEUE_DEPTH));
   assign take       = req_push && !req_full;
   assign link.valid = (count_ff != 2'd0);
   assign link.work  = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = take ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = work_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(take) - 2'(work_pop);
   end

   always_ff @(posedge clock) begin
      if (take) begin
         queue_mem[wr_ptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/rpg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_back
// Executes decoded work: PWM slot counting, color-loop stepping and gamma
// correction with brightness scaling on one shared 17x9 multiplier.
// ----------------------------------------------------------------------------
module rpg_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rpg_pkg::work_link_type link,
   output logic                   work_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output rpg_pkg::rsp_type       rsp_item
);
   import rpg_pkg::*;

   back_state_type state_ff, state_in;
   logic [8:0]  slot_ff, slot_in;
   logic [8:0]  active_ff [3];
   logic [8:0]  active_in [3];
   logic [8:0]  reload_ff [3];
   logic [8:0]  reload_in [3];
   logic [2:0]  pins_ff, pins_in;
   logic [1:0]  phase_ff, phase_in;
   logic [8:0]  color_ff [4];
   logic [8:0]  color_in [4];
   logic [1:0]  ch_ff, ch_in;
   logic [8:0]  chan_ff [3];
   logic [8:0]  chan_in [3];
   logic [8:0]  bs_ff, bs_in;
   logic [25:0] prod_ff, prod_in;
   logic [16:0] mul_a;
   logic [8:0]  mul_b;
   logic [25:0] mul_p;
   logic [10:0] g_sum;
   logic [8:0]  gamma;
   logic [1:0]  up, down, nxt;

   assign mul_p = {9'd0, mul_a} * {17'd0, mul_b};
   assign g_sum = {1'b0, prod_ff[24:15]} + 11'd1;
   assign gamma = g_sum[9:1];

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      active_in = active_ff;
      reload_in = reload_ff;
      pins_in   = pins_ff;
      phase_in  = phase_ff;
      color_in  = color_ff;
      ch_in     = ch_ff;
      chan_in   = chan_ff;
      bs_in     = bs_ff;
      prod_in   = prod_ff;
      work_pop  = 1'b0;
      rsp_push  = 1'b0;
      mul_a     = 17'd0;
      mul_b     = 9'd0;
      up        = 2'd0;
      down      = 2'd2;
      nxt       = PHASE_GRN;
      unique case (state_ff)
         ST_IDLE: begin
            if (link.valid && !rsp_full) begin
               work_pop = 1'b1;
               unique case (link.work.op)
                  OP_TICK: begin
                     if (slot_ff == 9'd0) begin
                        slot_in   = SLOT_TOP;
                        active_in = reload_ff;
                        pins_in   = 3'b111;
                     end else begin
                        for (int i = 0; i < 3; i++) begin
                           if (slot_ff == active_ff[i]) begin
                              pins_in[i] = 1'b0;
                           end
                        end
                        slot_in = slot_ff - 9'd1;
                     end
                     rsp_push = 1'b1;
                  end
                  OP_SET: begin
                     phase_in   = PHASE_IDLE;
                     chan_in[0] = link.work.red;
                     chan_in[1] = link.work.green;
                     chan_in[2] = link.work.blue;
                     bs_in      = link.work.brightness;
                     ch_in      = 2'd0;
                     state_in   = ST_SQ;
                  end
                  OP_LOOP: begin
                     phase_in    = PHASE_RED;
                     color_in[0] = 9'd0;
                     color_in[1] = 9'd0;
                     color_in[2] = LEVEL_MAX;
                     color_in[3] = LEVEL_MAX;
                     state_in    = ST_STEP;
                  end
                  OP_STEP: begin
                     state_in = ST_STEP;
                  end
                  OP_STOP: begin
                     phase_in = PHASE_IDLE;
                     rsp_push = 1'b1;
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         ST_STEP: begin
            unique case (phase_ff)
               PHASE_RED: begin
                  up = 2'd0; down = 2'd2; nxt = PHASE_GRN;
               end
               PHASE_GRN: begin
                  up = 2'd1; down = 2'd0; nxt = PHASE_BLU;
               end
               default: begin
                  up = 2'd2; down = 2'd1; nxt = PHASE_RED;
               end
            endcase
            if (phase_ff == PHASE_IDLE) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end else begin
               color_in[down] = color_ff[down] - 9'd1;
               color_in[up]   = color_ff[up] + 9'd1;
               if (color_in[up] == LEVEL_MAX) begin
                  phase_in = nxt;
               end
               for (int i = 0; i < 3; i++) begin
                  chan_in[i] = sat_level(color_in[i]);
               end
               bs_in    = sat_level(color_ff[3]);
               ch_in    = 2'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            mul_a    = {8'd0, chan_ff[ch_ff]};
            mul_b    = chan_ff[ch_ff];
            prod_in  = mul_p;
            state_in = ST_CU;
         end
         ST_CU: begin
            mul_a    = prod_ff[16:0];
            mul_b    = chan_ff[ch_ff];
            prod_in  = mul_p;
            state_in = ST_SC;
         end
         ST_SC: begin
            mul_a            = {8'd0, gamma};
            mul_b            = bs_ff;
            reload_in[ch_ff] = mul_p[16:8];
            if (ch_ff == CH_LAST) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_SQ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_item.red_pin        = pins_in[0];
      rsp_item.green_pin      = pins_in[1];
      rsp_item.blue_pin       = pins_in[2];
      rsp_item.effect_running = (phase_in != PHASE_IDLE);
   end

   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      chan_ff <= chan_in;
      bs_ff   <= bs_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         slot_ff   <= SLOT_TOP;
         active_ff <= '{default: 9'd0};
         reload_ff <= '{default: RELOAD_RST};
         pins_ff   <= 3'b111;
         phase_ff  <= PHASE_IDLE;
         color_ff  <= '{default: 9'd0};
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         active_ff <= active_in;
         reload_ff <= reload_in;
         pins_ff   <= pins_in;
         phase_ff  <= phase_in;
         color_ff  <= color_in;
      end
   end

endmodule

[rtl/core/rpg_rsp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_rsp_queue
// Two-entry result queue between the back end and the response port.
// ----------------------------------------------------------------------------
module rpg_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rpg_pkg::rsp_type push_item,
   output logic             full,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output rpg_pkg::rsp_type rsp_item
);
   import rpg_pkg::*;

   rsp_type    queue_mem [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       take;
   logic       give;

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_item  = queue_mem[rd_ptr_ff];
   assign take      = push && !full;
   assign give      = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = take ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = give ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(take) - 2'(give);
   end

   always_ff @(posedge clock) begin
      if (take) begin
         queue_mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[dv/rgb_pin_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pin_checker
// Watches the request and response queues of the RGB PWM unit. For every
// accepted request it predicts the pin levels and the effect flag from its
// own copy of the counter, duties and color-loop state, and compares each
// response transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_pin_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  rpg_pkg::req_type req_item,
   input  logic             rsp_pop,
   input  logic             rsp_empty,
   input  rpg_pkg::rsp_type rsp_item,
   output int               fail_count,
   output int               pending_pins
);
   import rpg_pkg::*;

   logic [8:0] slot_ctr;
   logic [8:0] duty_now [3];
   logic [8:0] duty_next [3];
   logic [2:0] pin_lvl;
   logic [1:0] fade_phase;
   logic [8:0] fade_level [4];
   rsp_type    expected_pins [$];
   int         mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH %0t ns: %s", $time, what);
   endtask

   task automatic check_pin(input string name, input logic got, input logic want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %b want %b", name, got, want));
      end
   endtask

   function automatic logic [8:0] corrected_duty(input logic [8:0] level,
                                                 input logic [8:0] bright);
      logic [63:0] lv;
      logic [63:0] bs;
      logic [63:0] acc;
      lv  = 64'((level > LEVEL_MAX) ? LEVEL_MAX : level);
      bs  = 64'((bright > LEVEL_MAX) ? LEVEL_MAX : bright);
      acc = (((lv * lv * lv * 64'd256) >> 23) + 64'd1) >> 1;
      acc = (acc * bs) >> 8;
      return acc[8:0];
   endfunction

   function automatic void load_color(input logic [8:0] r, input logic [8:0] g,
                                      input logic [8:0] b, input logic [8:0] br);
      duty_next[0] = corrected_duty(r, br);
      duty_next[1] = corrected_duty(g, br);
      duty_next[2] = corrected_duty(b, br);
   endfunction

   function automatic void fade_advance();
      int         up;
      int         down;
      logic [1:0] next_phase;
      up         = 0;
      down       = 0;
      next_phase = PHASE_IDLE;
      case (fade_phase)
         PHASE_RED: begin
            up = 0; down = 2; next_phase = PHASE_GRN;
         end
         PHASE_GRN: begin
            up = 1; down = 0; next_phase = PHASE_BLU;
         end
         PHASE_BLU: begin
            up = 2; down = 1; next_phase = PHASE_RED;
         end
         default: return;
      endcase
      fade_level[down] = fade_level[down] - 9'd1;
      fade_level[up]   = fade_level[up] + 9'd1;
      if (fade_level[up] == LEVEL_MAX) begin
         fade_phase = next_phase;
      end
      load_color(fade_level[0], fade_level[1], fade_level[2], fade_level[3]);
   endfunction

   function automatic void pwm_advance();
      if (slot_ctr == 9'd0) begin
         slot_ctr = SLOT_TOP;
         for (int i = 0; i < 3; i++) duty_now[i] = duty_next[i];
         pin_lvl = 3'b111;
      end else begin
         for (int i = 0; i < 3; i++) begin
            if (slot_ctr == duty_now[i]) pin_lvl[i] = 1'b0;
         end
         slot_ctr = slot_ctr - 9'd1;
      end
   endfunction

   function automatic void clear_model();
      slot_ctr = SLOT_TOP;
      for (int i = 0; i < 3; i++) begin
         duty_now[i]  = 9'd0;
         duty_next[i] = RELOAD_RST;
      end
      pin_lvl    = 3'b111;
      fade_phase = PHASE_IDLE;
      for (int i = 0; i < 4; i++) fade_level[i] = 9'd0;
   endfunction

   function automatic rsp_type predict_pins(input req_type item);
      rsp_type pins;
      case (item.kind)
         KIND_TICK: pwm_advance();
         KIND_SET: begin
            fade_phase = PHASE_IDLE;
            load_color(item.red, item.green, item.blue, item.brightness);
         end
         KIND_LOOP: begin
            fade_phase    = PHASE_RED;
            fade_level[0] = 9'd0;
            fade_level[1] = 9'd0;
            fade_level[2] = LEVEL_MAX;
            fade_level[3] = LEVEL_MAX;
            fade_advance();
         end
         KIND_STEP: fade_advance();
         KIND_STOP: fade_phase = PHASE_IDLE;
         default: ;
      endcase
      pins.red_pin        = pin_lvl[0];
      pins.green_pin      = pin_lvl[1];
      pins.blue_pin       = pin_lvl[2];
      pins.effect_running = (fade_phase != PHASE_IDLE);
      return pins;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_model();
         expected_pins.delete();
         pending_pins <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_pins.size() == 0) begin
               report_mismatch($sformatf("response transaction %b with none expected",
                                         rsp_item));
            end else begin
               want = expected_pins.pop_front();
               check_pin("red_pin", rsp_item.red_pin, want.red_pin);
               check_pin("green_pin", rsp_item.green_pin, want.green_pin);
               check_pin("blue_pin", rsp_item.blue_pin, want.blue_pin);
               check_pin("effect_running", rsp_item.effect_running,
                         want.effect_running);
            end
         end
         if (req_push && !req_full) begin
            expected_pins.push_back(predict_pins(req_item));
         end
         pending_pins <= expected_pins.size();
      end
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the RGB PWM gamma color-loop unit. A short
// directed sequence hits the field extremes, saturation, every request kind
// and the idle and unused cases; a full three-phase color loop follows, then
// random PWM periods, color changes, short loops and noise, with bursty requests
// and a stalling response side. Checking is done by rgb_pin_checker.
// ----------------------------------------------------------------------------
module testbench;
   import rpg_pkg::*;

   localparam int         ITEM_TARGET   = 1300;
   localparam int         LOOP_STEPS    = 780;
   localparam int         HOLD_CYCLES   = 120;
   localparam int         QUIET_LIMIT   = 3000;
   localparam int         DRAIN_CYCLES  = 30;
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_item = '0;
   logic    rsp_pop  = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_item;
   int      fail_count;
   int      pending_pins;
   bit      hold_rsp   = 1'b0;
   int      items_sent = 0;
   int      burst_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rgb_pwm_gamma_colorloop_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

   rgb_pin_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_item     (req_item),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_item     (rsp_item),
      .fail_count   (fail_count),
      .pending_pins (pending_pins)
   );

   function automatic req_type rand_item(input logic [2:0] kind);
      req_type item;
      item.kind       = kind;
      item.red        = 9'($urandom_range(0, 511));
      item.green      = 9'($urandom_range(0, 511));
      item.blue       = 9'($urandom_range(0, 511));
      item.brightness = 9'($urandom_range(0, 511));
      return item;
   endfunction

   function automatic logic [8:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 9'd0;
         1:       return LEVEL_MAX;
         2, 3:    return 9'($urandom_range(0, 256));
         4:       return 9'($urandom_range(0, 511));
         default: return 9'($urandom_range(1, 24));
      endcase
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_item <= item;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(rand_item(KIND_TICK));
   endtask

   task automatic drain_pause();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_pins != 0);
   endtask

   // response side: stall pattern is redrawn after each span of random length
   initial begin
      int style;
      int span;
      int beat;
      bit pop_now;
      beat = 0;
      wait (!reset);
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(50, 200);
         repeat (span) begin
            @(posedge clock);
            if (hold_rsp) begin
               hold_rsp = 1'b0;
               rsp_pop <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end else begin
               beat++;
               case (style)
                  0:       pop_now = 1'b1;
                  1:       pop_now = 1'($urandom_range(0, 1));
                  2:       pop_now = (beat % 4 == 0);
                  default: pop_now = ($urandom_range(0, 7) == 0);
               endcase
               rsp_pop <= pop_now;
            end
         end
      end
   end

   // watchdog: end the run after a long stretch with no transaction
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      req_type item;
      int      fade_steps;
      int      run;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(rand_item(KIND_TICK));
      send_item(req_type'{KIND_SET, 9'd256, 9'd256, 9'd256, 9'd256});
      send_item(req_type'{KIND_SET, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF});
      send_item(req_type'{KIND_SET, 9'd0, 9'd0, 9'd0, 9'd0});
      send_item(req_type'{KIND_SET, 9'h155, 9'h0AA, 9'h100, 9'h0FF});
      send_item(req_type'{KIND_SET, 9'h0AA, 9'h155, 9'h001, 9'h1FF});
      send_item(req_type'{KIND_SET, 9'd200, 9'd0, 9'd256, 9'd0});
      send_item(rand_item(KIND_LOOP));
      send_item(rand_item(KIND_STEP));
      send_item(rand_item(KIND_STOP));
      send_item(rand_item(KIND_STEP));
      for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) send_item(rand_item(3'(k)));
      send_item(rand_item(KIND_LOOP));
      send_item(req_type'{KIND_SET, 9'd256, 9'd100, 9'd30, 9'd256});
      send_ticks(3);
      drain_pause();

      // full color loop through all three phases; responses are held once as it starts
      hold_rsp = 1'b1;
      send_item(rand_item(KIND_LOOP));
      fade_steps = 0;
      while (fade_steps < LOOP_STEPS) begin
         if ($urandom_range(0, 7) == 0) begin
            send_item(rand_item(KIND_TICK));
         end else begin
            send_item(rand_item(KIND_STEP));
            fade_steps++;
         end
      end
      drain_pause();

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_ticks($urandom_range(1, 150));
            4, 5: begin
               item            = rand_item(KIND_SET);
               item.red        = pick_level();
               item.green      = pick_level();
               item.blue       = pick_level();
               item.brightness = pick_level();
               send_item(item);
               send_ticks($urandom_range(0, 40));
            end
            6, 7: begin
               send_item(rand_item(KIND_LOOP));
               run = $urandom_range(1, 60);
               repeat (run) begin
                  send_item(rand_item(($urandom_range(0, 3) == 0) ? KIND_TICK : KIND_STEP));
               end
               if ($urandom_range(0, 1) == 1) send_item(rand_item(KIND_STOP));
            end
            8: begin
               repeat ($urandom_range(1, 10)) begin
                  send_item(rand_item(3'($urandom_range(KIND_TICK, KIND_SPARE_HI))));
               end
            end
            default: begin
               drain_pause();
               send_item(rand_item(KIND_STOP));
               repeat ($urandom_range(1, 3)) send_item(rand_item(KIND_STEP));
            end
         endcase
      end

      req_push <= 1'b0;
      do @(posedge clock); while (pending_pins != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/rpg_pkg.sv
rtl/core/rpg_front.sv
rtl/core/rpg_back.sv
rtl/core/rpg_rsp_queue.sv
rtl/core/rgb_pwm_gamma_colorloop_unit.sv
dv/rgb_pin_checker.sv
dv/testbench.sv
